/* rtl/metric_collect_and_elect_top_macros.svh */
// Assertion macros for the metric collect and elect block.
// Used by the top level; expects signals named clk and arst_n in scope.
`ifndef METRIC_COLLECT_AND_ELECT_TOP_MACROS_SVH
`define METRIC_COLLECT_AND_ELECT_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MCE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MCE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mce_pkg.sv */
// Package for the metric collect and elect block: sizes, codes and record types.
// Used by mce_elect and the top level; depends on nothing.
`timescale 1ns / 1ps

package mce_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int ID_W        = 64;
	localparam int RTT_W       = 40;
	localparam int KBPS_W      = 32;
	localparam int TIME_W      = 64;
	localparam int OP_W        = 3;
	localparam int SCORE_W     = RTT_W + 1;

	typedef enum logic [OP_W-1:0] {
		OP_START       = 3'd0,
		OP_ADD         = 3'd1,
		OP_COLL_DONE   = 3'd2,
		OP_ELECT       = 3'd3,
		OP_RESET_IDLE  = 3'd4,
		OP_READ_METRIC = 3'd5,
		OP_READ_RESULT = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		CTRL_IDLE    = 2'd0,
		CTRL_COLLECT = 2'd1,
		CTRL_START   = 2'd2,
		CTRL_DONE    = 2'd3
	} ctrl_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_STATE = 2'd1,
		ST_PARAM = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_ACCEPT = 2'd0,
		S_READ_A = 2'd1,
		S_READ_B = 2'd2,
		S_SCAN   = 2'd3
	} fsm_t;

	// One stored participant metric.
	typedef struct packed {
		logic [ID_W-1:0]   id_high;
		logic [ID_W-1:0]   id_low;
		logic [RTT_W-1:0]  rtt;
		logic [KBPS_W-1:0] kbps;
	} entry_t;

	// One result transaction.
	typedef struct packed {
		status_t           status;
		ctrl_t             ctrl_now;
		logic [CNT_W-1:0]  count_now;
		logic [ID_W-1:0]   first_id_high;
		logic [ID_W-1:0]   first_id_low;
		logic [ID_W-1:0]   second_id_high;
		logic [ID_W-1:0]   second_id_low;
		logic [RTT_W-1:0]  read_rtt_ns;
		logic [KBPS_W-1:0] read_kbps;
		logic [TIME_W-1:0] elected_at_ns;
	} result_t;

	// Scan stream from the controller into the election unit.
	typedef struct packed {
		logic              clear;
		logic              vld;
		logic [IDX_W-1:0]  idx;
		logic [RTT_W-1:0]  rtt;
		logic [KBPS_W-1:0] kbps;
	} elect_in_t;

endpackage

/* rtl/mce_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module mce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/mce_elect.sv */
// Election unit: keeps the lowest and second-lowest score of a streamed scan.
// Depends on mce_pkg.
`timescale 1ns / 1ps

module mce_elect
	import mce_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  elect_in_t        el,
	output logic [IDX_W-1:0] host_pick,
	output logic [IDX_W-1:0] backup_pick
);

	logic signed [SCORE_W-1:0] score;
	logic signed [SCORE_W-1:0] best_score_q;
	logic signed [SCORE_W-1:0] bk_score_q;
	logic [IDX_W-1:0]          best_q;
	logic [IDX_W-1:0]          backup_q;
	logic                      has_bk_q;
	logic                      first;
	logic                      take_best;
	logic                      take_bk;

	// Score is rtt minus bandwidth; lower wins, a strict win is needed to displace.
	assign score     = SCORE_W'(el.rtt) - SCORE_W'(el.kbps);
	assign first     = el.vld && (el.idx == '0);
	assign take_best = el.vld && !first && (score < best_score_q);
	assign take_bk   = el.vld && !first && !take_best && (!has_bk_q || (score < bk_score_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q   <= '0;
			backup_q <= '0;
			has_bk_q <= 1'b0;
		end else if (el.clear) begin
			best_q   <= '0;
			backup_q <= '0;
			has_bk_q <= 1'b0;
		end else if (first) begin
			best_q   <= '0;
			has_bk_q <= 1'b0;
		end else if (take_best) begin
			backup_q <= best_q;
			best_q   <= el.idx;
			has_bk_q <= 1'b1;
		end else if (take_bk) begin
			backup_q <= el.idx;
			has_bk_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (first) begin
			best_score_q <= score;
		end else if (take_best) begin
			bk_score_q   <= best_score_q;
			best_score_q <= score;
		end else if (take_bk) begin
			bk_score_q <= score;
		end
	end

	assign host_pick   = best_q;
	assign backup_pick = backup_q;

endmodule

/* rtl/metric_collect_and_elect_top.sv */
// Top level of the metric collect and elect block: round controller and store.
// Depends on mce_pkg, mce_ram, mce_elect and metric_collect_and_elect_top_macros.svh.
//
// Usage: one input transaction carries one operation (op) with its operands; each
// input transaction yields exactly one output transaction, in order. Both channels
// use valid/stall; a transaction moves on a rising edge with valid high, stall low.
// Metrics live in a 64-entry synchronous RAM, one read port with registered read data.
// Start, add, collection done, reset and failed operations go straight to the
// staging register; read metric first reads one RAM entry; read result reads two
// (host and backup ids are read one after the other on the single RAM port); a
// successful elect scans all stored metrics, reading one entry per cycle while
// the election unit compares one score per cycle, and releases its result when
// the last score is compared.
// A finished result waits in a staging register while the output register is
// stalled, so the next input transaction is taken while an earlier result is
// still held at the output; input stalls only when the staging register is full
// or a multi-cycle operation is in progress. Reset clears the controller to idle,
// the count, the picks and the election time; the RAM is not cleared, and entries
// are only ever read below the count of written ones.
`timescale 1ns / 1ps
`include "metric_collect_and_elect_top_macros.svh"

module metric_collect_and_elect_top
	import mce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   op,
	input  logic [ID_W-1:0]   id_high,
	input  logic [ID_W-1:0]   id_low,
	input  logic [RTT_W-1:0]  rtt_ns,
	input  logic [KBPS_W-1:0] uplink_kbps,
	input  logic              is_leader,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [TIME_W-1:0] now_ns,
	// Output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [1:0]        ctrl_now,
	output logic [CNT_W-1:0]  count_now,
	output logic [ID_W-1:0]   first_id_high,
	output logic [ID_W-1:0]   first_id_low,
	output logic [ID_W-1:0]   second_id_high,
	output logic [ID_W-1:0]   second_id_low,
	output logic [RTT_W-1:0]  read_rtt_ns,
	output logic [KBPS_W-1:0] read_kbps,
	output logic [TIME_W-1:0] elected_at_ns
);

	// Controller state.
	fsm_t              state_q, state_d;
	ctrl_t             ctrl_q, ctrl_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [TIME_W-1:0] time_q, time_d;
	op_t               op_q, op_d;
	logic [CNT_W-1:0]  scan_q, scan_d;

	// Staging register and output register.
	result_t           res_q, res_d;
	logic              res_vld_q, res_vld_d;
	result_t           out_q;
	logic              out_vld_q;

	// Scan pipeline, aligned with the RAM read data.
	logic              scan_vld_s1;
	logic [IDX_W-1:0]  scan_idx_s1;
	logic              scan_last_s1;
	logic              scan_issue;

	// Handshake and decode.
	logic              accept;
	logic              move;
	op_t               op_in;
	status_t           acc_status;

	// RAM port.
	logic              mem_we;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	entry_t            mem_wdata;
	entry_t            mem_rdata;

	// Election unit.
	elect_in_t         el;
	logic [IDX_W-1:0]  host_pick;
	logic [IDX_W-1:0]  backup_pick;

	mce_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	mce_elect u_elect (
		.clk         (clk),
		.arst_n      (arst_n),
		.el          (el),
		.host_pick   (host_pick),
		.backup_pick (backup_pick)
	);

	assign op_in      = op_t'(op);
	assign in_stall   = (state_q != S_ACCEPT) || res_vld_q;
	assign accept     = in_valid && !in_stall;
	assign move       = res_vld_q && (!out_vld_q || !out_stall);
	assign mem_wdata  = {id_high, id_low, rtt_ns, uplink_kbps};
	assign scan_issue = (state_q == S_SCAN) && (scan_q < count_q);

	always_comb begin
		state_d    = state_q;
		ctrl_d     = ctrl_q;
		count_d    = count_q;
		time_d     = time_q;
		op_d       = op_q;
		scan_d     = scan_q;
		res_d      = res_q;
		res_vld_d  = res_vld_q && !move;
		acc_status = ST_OK;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = scan_q[IDX_W-1:0];
		el.clear   = 1'b0;
		el.vld     = scan_vld_s1;
		el.idx     = scan_idx_s1;
		el.rtt     = mem_rdata.rtt;
		el.kbps    = mem_rdata.kbps;

		case (state_q)
			S_ACCEPT: begin
				if (accept) begin
					op_d = op_in;
					res_d = '0;
					res_vld_d = 1'b1;
					case (op_in)
						OP_START: begin
							if (ctrl_q != CTRL_IDLE) begin
								acc_status = ST_STATE;
							end else begin
								count_d  = '0;
								time_d   = '0;
								el.clear = 1'b1;
								ctrl_d   = CTRL_COLLECT;
							end
						end
						OP_ADD: begin
							if (ctrl_q != CTRL_COLLECT) begin
								acc_status = ST_STATE;
							end else if (count_q >= CNT_W'(MAX_ENTRIES)) begin
								acc_status = ST_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
						end
						OP_COLL_DONE: begin
							if (ctrl_q != CTRL_COLLECT) begin
								acc_status = ST_STATE;
							end else begin
								ctrl_d = is_leader ? CTRL_START : CTRL_IDLE;
							end
						end
						OP_ELECT: begin
							if (ctrl_q != CTRL_START) begin
								acc_status = ST_STATE;
							end else if (count_q < CNT_W'(2)) begin
								acc_status = ST_PARAM;
							end else begin
								// Result is released when the last score is compared.
								time_d    = now_ns;
								ctrl_d    = CTRL_DONE;
								scan_d    = '0;
								res_vld_d = 1'b0;
								state_d   = S_SCAN;
							end
						end
						OP_RESET_IDLE: begin
							if (ctrl_q != CTRL_DONE) begin
								acc_status = ST_STATE;
							end else begin
								ctrl_d = CTRL_IDLE;
							end
						end
						OP_READ_METRIC: begin
							// The index check comes before the state check.
							if (CNT_W'(entry_index) >= count_q) begin
								acc_status = ST_PARAM;
							end else if (ctrl_q == CTRL_IDLE) begin
								acc_status = ST_STATE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = entry_index;
								res_vld_d = 1'b0;
								state_d   = S_READ_A;
							end
						end
						OP_READ_RESULT: begin
							if (ctrl_q != CTRL_DONE) begin
								acc_status = ST_STATE;
							end else begin
								mem_re              = 1'b1;
								mem_raddr           = host_pick;
								res_d.elected_at_ns = time_q;
								res_vld_d           = 1'b0;
								state_d             = S_READ_A;
							end
						end
						default: begin
							acc_status = ST_PARAM;
						end
					endcase
					res_d.status    = acc_status;
					res_d.ctrl_now  = ctrl_d;
					res_d.count_now = count_d;
				end
			end
			S_READ_A: begin
				res_d.first_id_high = mem_rdata.id_high;
				res_d.first_id_low  = mem_rdata.id_low;
				if (op_q == OP_READ_METRIC) begin
					res_d.read_rtt_ns = mem_rdata.rtt;
					res_d.read_kbps   = mem_rdata.kbps;
					res_vld_d         = 1'b1;
					state_d           = S_ACCEPT;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = backup_pick;
					state_d   = S_READ_B;
				end
			end
			S_READ_B: begin
				res_d.second_id_high = mem_rdata.id_high;
				res_d.second_id_low  = mem_rdata.id_low;
				res_vld_d            = 1'b1;
				state_d              = S_ACCEPT;
			end
			S_SCAN: begin
				if (scan_issue) begin
					mem_re = 1'b1;
					scan_d = scan_q + CNT_W'(1);
				end
				if (scan_vld_s1 && scan_last_s1) begin
					res_vld_d = 1'b1;
					state_d   = S_ACCEPT;
				end
			end
			default: begin
				state_d = S_ACCEPT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACCEPT;
			ctrl_q      <= CTRL_IDLE;
			count_q     <= '0;
			time_q      <= '0;
			res_vld_q   <= 1'b0;
			out_vld_q   <= 1'b0;
			scan_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			ctrl_q      <= ctrl_d;
			count_q     <= count_d;
			time_q      <= time_d;
			res_vld_q   <= res_vld_d;
			out_vld_q   <= move || (out_vld_q && out_stall);
			scan_vld_s1 <= scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		op_q         <= op_d;
		scan_q       <= scan_d;
		res_q        <= res_d;
		scan_idx_s1  <= scan_q[IDX_W-1:0];
		scan_last_s1 <= (scan_q == (count_q - CNT_W'(1)));
		if (move) begin
			out_q <= res_q;
		end
	end

	assign out_valid      = out_vld_q;
	assign status         = out_q.status;
	assign ctrl_now       = out_q.ctrl_now;
	assign count_now      = out_q.count_now;
	assign first_id_high  = out_q.first_id_high;
	assign first_id_low   = out_q.first_id_low;
	assign second_id_high = out_q.second_id_high;
	assign second_id_low  = out_q.second_id_low;
	assign read_rtt_ns    = out_q.read_rtt_ns;
	assign read_kbps      = out_q.read_kbps;
	assign elected_at_ns  = out_q.elected_at_ns;

	// The count never passes the store depth.
	`MCE_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_ENTRIES), "count beyond store depth")
	// A store write only happens for an accepted add with room left.
	`MCE_ASSERT_IMP(a_write_room, mem_we, (state_q == S_ACCEPT) && (count_q < CNT_W'(MAX_ENTRIES)), "store write without room")
	// A completed election always had at least two entries.
	`MCE_ASSERT_IMP(a_done_two, ctrl_q == CTRL_DONE, count_q >= CNT_W'(2), "election done with fewer than two entries")
	// Scan data only arrives while the scan is running.
	`MCE_ASSERT_IMP(a_scan_data, scan_vld_s1, state_q == S_SCAN, "scan data outside the scan")
	// The last compared score releases the elect result and frees the controller.
	`MCE_ASSERT_NXT(a_scan_end, scan_vld_s1 && scan_last_s1, res_vld_q && (state_q == S_ACCEPT), "scan end without result")

endmodule
